@@ hdl/mmd_pkg.sv @@
`default_nettype none
package mmd_pkg;

  localparam int DMA_LENGTH = 160;
  localparam int BOOT_IMAGE_BYTES = 256;
  localparam int RAM_BYTES = 8192;
  localparam int RAM_AW = $clog2(RAM_BYTES);
  localparam int HIGH_BYTES = 127;
  localparam int SPRITE_BYTES = 'hA0;

  localparam logic [15:0] BOOT_END = 16'h0100;
  localparam logic [15:0] OAM_BASE = 16'hFE00;
  localparam logic [15:0] OAM_END = 16'hFEA0;
  localparam logic [15:0] DMA_REG = 16'hFF46;
  localparam logic [15:0] BOOT_REG = 16'hFF50;
  localparam logic [15:0] HRAM_BASE = 16'hFF80;
  localparam logic [15:0] IF_REG = 16'hFF0F;
  localparam logic [15:0] IE_REG = 16'hFFFF;
  localparam logic [15:0] LY_REG = 16'hFF44;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_LOAD  = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    DEV_NONE   = 3'd0,
    DEV_CART   = 3'd1,
    DEV_APU    = 3'd2,
    DEV_JOYPAD = 3'd3,
    DEV_SERIAL = 3'd4,
    DEV_TIMER  = 3'd5,
    DEV_PPU    = 3'd6
  } dev_t;

  typedef enum logic [2:0] {
    SRC_BYTE,
    SRC_VRAM,
    SRC_WRAM,
    SRC_HRAM,
    SRC_BOOT,
    SRC_OAM
  } rsrc_t;

  // external device for an access, none when answered locally or unmapped
  function automatic dev_t dev_of(logic [15:0] a, logic is_write, logic boot_mapped);
    dev_t d;
    d = DEV_NONE;
    if (a < 16'h8000) begin
      d = (!is_write && boot_mapped && a < BOOT_END) ? DEV_NONE : DEV_CART;
    end else if (a >= 16'hA000 && a <= 16'hBFFF) begin
      d = DEV_CART;
    end else if (a >= 16'hFF10 && a <= 16'hFF3F) begin
      d = DEV_APU;
    end else if (a == 16'hFF00) begin
      d = DEV_JOYPAD;
    end else if (a == 16'hFF01 || a == 16'hFF02) begin
      d = DEV_SERIAL;
    end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
      d = DEV_TIMER;
    end else if (a >= 16'hFF40 && a <= 16'hFF4B && a != DMA_REG) begin
      d = (is_write && a == LY_REG) ? DEV_NONE : DEV_PPU;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

@@ hdl/memory_map_decoder_with_oam_dma.sv @@
`default_nettype none
// Bus decoder with local video RAM, work RAM, sprite table, high RAM, boot image,
// interrupt registers and sprite-table DMA. Items are taken one per clock whenever
// busy is low; each item gives exactly one result on out_strobe in the next cycle,
// and the receiver cannot stall it. Memory reads and all writes except sprite
// table writes happen at the accept edge; the result is formed from the
// registered read data. Sprite table writes land in the following cycle and are
// forwarded to a read at that same edge. After reset busy stays high while the
// video RAM is cleared one byte a cycle; configuration writes are taken at any
// time.
module memory_map_decoder_with_oam_dma (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [1:0]  in_ppu_mode,
  input  wire logic [7:0]  in_device_read_data,
  // result channel
  output logic             out_strobe,
  output logic [7:0]       out_read_data,
  output logic [2:0]       out_device_select,
  output logic [15:0]      out_device_address,
  output logic             out_device_write,
  output logic [7:0]       out_device_write_data,
  output logic             out_dma_active,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata
);

  // memories
  logic [7:0] vram [mmd_pkg::RAM_BYTES];
  logic [7:0] wram [mmd_pkg::RAM_BYTES];
  logic [7:0] hram [mmd_pkg::HIGH_BYTES];
  logic [7:0] boot [mmd_pkg::BOOT_IMAGE_BYTES];
  logic [7:0] oam  [mmd_pkg::SPRITE_BYTES];
  logic [mmd_pkg::SPRITE_BYTES-1:0] oam_vld_r;

  // architectural state
  logic        boot_mapped_r, boot_mapped_nxt;
  logic        dma_run_r, dma_run_nxt;
  logic [15:0] dma_src_r, dma_src_nxt;
  logic [7:0]  dma_idx_r, dma_idx_nxt;
  logic [7:0]  ie_r, ie_nxt;
  logic [7:0]  if_r, if_nxt;
  logic [mmd_pkg::RAM_AW:0] clr_r;

  // result stage
  logic             v_r;
  mmd_pkg::rsrc_t   src_r, src_nxt;
  logic [7:0]       byte_r, byte_nxt;
  mmd_pkg::dev_t    sel_r, sel_nxt;
  logic [15:0]      daddr_r, daddr_nxt;
  logic             dwr_r, dwr_nxt;
  logic [7:0]       dwdata_r, dwdata_nxt;
  logic             dact_r;
  logic             oam_we_r, oam_we_nxt;
  logic [7:0]       oam_idx_r, oam_idx_nxt;
  logic             oam_dma_r, oam_dma_nxt;
  logic [7:0]       oam_wd_r;
  logic [7:0]       vram_q_r, wram_q_r, hram_q_r, boot_q_r, oam_q_r;

  logic        acc;
  logic [15:0] a;
  logic        rd_en;
  logic [7:0]  rd_data;
  logic [7:0]  oam_wdata;
  logic        vram_we, wram_we, hram_we, boot_we;
  logic [7:0]  dma_idx_inc;

  assign busy = !clr_r[mmd_pkg::RAM_AW];
  assign acc  = start && !busy;

  // read path of the result stage
  always_comb begin
    unique case (src_r)
      mmd_pkg::SRC_VRAM: rd_data = vram_q_r;
      mmd_pkg::SRC_WRAM: rd_data = wram_q_r;
      mmd_pkg::SRC_HRAM: rd_data = hram_q_r;
      mmd_pkg::SRC_BOOT: rd_data = boot_q_r;
      mmd_pkg::SRC_OAM:  rd_data = oam_q_r;
      default:           rd_data = byte_r;
    endcase
  end

  assign oam_wdata = oam_dma_r ? rd_data : oam_wd_r;

  // decode of the incoming item
  always_comb begin
    boot_mapped_nxt = boot_mapped_r;
    dma_run_nxt = dma_run_r;
    dma_src_nxt = dma_src_r;
    dma_idx_nxt = dma_idx_r;
    ie_nxt = ie_r;
    if_nxt = if_r;
    src_nxt = mmd_pkg::SRC_BYTE;
    byte_nxt = 8'h00;
    sel_nxt = mmd_pkg::DEV_NONE;
    daddr_nxt = 16'h0000;
    dwr_nxt = 1'b0;
    dwdata_nxt = 8'h00;
    oam_we_nxt = 1'b0;
    oam_idx_nxt = in_address[7:0];
    oam_dma_nxt = 1'b0;
    vram_we = 1'b0;
    wram_we = 1'b0;
    hram_we = 1'b0;
    boot_we = 1'b0;
    dma_idx_inc = dma_idx_r + 8'd1;

    // source of a read: the bus address, or the dma source byte
    rd_en = (mmd_pkg::act_t'(in_action) == mmd_pkg::ACT_READ)
         || (mmd_pkg::act_t'(in_action) == mmd_pkg::ACT_TICK && dma_run_r);
    a = (mmd_pkg::act_t'(in_action) == mmd_pkg::ACT_TICK) ? dma_src_r + {8'h00, dma_idx_r}
                                                          : in_address;

    if (rd_en) begin
      sel_nxt = mmd_pkg::dev_of(a, 1'b0, boot_mapped_r);
      if (sel_nxt != mmd_pkg::DEV_NONE) begin
        daddr_nxt = a;
        byte_nxt = in_device_read_data;
      end else if (a < mmd_pkg::BOOT_END && boot_mapped_r) begin
        src_nxt = mmd_pkg::SRC_BOOT;
      end else if (a >= 16'h8000 && a < 16'hA000) begin
        src_nxt = mmd_pkg::SRC_VRAM;
      end else if (a >= 16'hC000 && a < 16'hE000) begin
        src_nxt = mmd_pkg::SRC_WRAM;
      end else if (a >= mmd_pkg::OAM_BASE && a < mmd_pkg::OAM_END) begin
        if (in_ppu_mode[1]) begin
          byte_nxt = 8'hFF;
        end else if (v_r && oam_we_r && oam_idx_r == a[7:0]) begin
          byte_nxt = oam_wdata;   // write landing at this edge
        end else if (!oam_vld_r[a[7:0]]) begin
          byte_nxt = 8'hFF;
        end else begin
          src_nxt = mmd_pkg::SRC_OAM;
        end
      end else if (a == mmd_pkg::IF_REG) begin
        byte_nxt = if_r;
      end else if (a == mmd_pkg::DMA_REG) begin
        byte_nxt = dma_src_r[15:8];
      end else if (a == mmd_pkg::BOOT_REG) begin
        byte_nxt = {7'd0, boot_mapped_r};
      end else if (a >= mmd_pkg::HRAM_BASE && a < mmd_pkg::IE_REG) begin
        src_nxt = mmd_pkg::SRC_HRAM;
      end else if (a == mmd_pkg::IE_REG) begin
        byte_nxt = ie_r;
      end else begin
        byte_nxt = 8'hFF;
      end
    end

    priority case (mmd_pkg::act_t'(in_action))
      mmd_pkg::ACT_WRITE: begin
        sel_nxt = mmd_pkg::dev_of(in_address, 1'b1, boot_mapped_r);
        if (sel_nxt != mmd_pkg::DEV_NONE) begin
          daddr_nxt = in_address;
          dwr_nxt = 1'b1;
          dwdata_nxt = in_write_data;
        end else if (in_address >= 16'h8000 && in_address < 16'hA000) begin
          vram_we = 1'b1;
        end else if (in_address >= 16'hC000 && in_address < 16'hE000) begin
          wram_we = 1'b1;
        end else if (in_address >= mmd_pkg::OAM_BASE && in_address < mmd_pkg::OAM_END) begin
          oam_we_nxt = 1'b1;
        end else if (in_address == mmd_pkg::IF_REG) begin
          if_nxt = in_write_data;
        end else if (in_address == mmd_pkg::DMA_REG) begin
          dma_run_nxt = 1'b1;
          dma_idx_nxt = 8'h00;
          dma_src_nxt = {in_write_data, 8'h00};
        end else if (in_address == mmd_pkg::BOOT_REG) begin
          if (in_write_data != 8'h00) begin
            boot_mapped_nxt = 1'b0;
          end
        end else if (in_address >= mmd_pkg::HRAM_BASE && in_address < mmd_pkg::IE_REG) begin
          hram_we = 1'b1;
        end else if (in_address == mmd_pkg::IE_REG) begin
          ie_nxt = in_write_data;
        end
      end
      mmd_pkg::ACT_TICK: begin
        if (dma_run_r) begin
          oam_we_nxt = 1'b1;
          oam_dma_nxt = 1'b1;
          oam_idx_nxt = dma_idx_r;
          dma_idx_nxt = dma_idx_inc;
          if (dma_idx_inc >= 8'(mmd_pkg::DMA_LENGTH)) begin
            dma_run_nxt = 1'b0;
            dma_idx_nxt = 8'h00;
            dma_src_nxt = 16'h0000;
          end
        end
      end
      mmd_pkg::ACT_LOAD: begin
        boot_we = (in_address < 16'(mmd_pkg::BOOT_IMAGE_BYTES));
      end
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      v_r <= 1'b0;
      boot_mapped_r <= 1'b1;
      dma_run_r <= 1'b0;
      dma_src_r <= 16'h0000;
      dma_idx_r <= 8'h00;
      ie_r <= 8'h00;
      if_r <= 8'h00;
      oam_vld_r <= '0;
      oam_we_r <= 1'b0;
    end else begin
      if (busy) begin
        clr_r <= clr_r + 1'b1;
      end
      v_r <= acc;
      oam_we_r <= acc && oam_we_nxt;
      if (v_r && oam_we_r) begin
        oam_vld_r[oam_idx_r] <= 1'b1;
      end
      if (acc) begin
        dma_run_r <= dma_run_nxt;
        dma_src_r <= dma_src_nxt;
        dma_idx_r <= dma_idx_nxt;
        ie_r <= ie_nxt;
        if_r <= if_nxt;
      end
      // a register write also reloads the boot mapping
      if (cfg_we) begin
        boot_mapped_r <= cfg_wdata;
      end else if (acc) begin
        boot_mapped_r <= boot_mapped_nxt;
      end
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      src_r <= src_nxt;
      byte_r <= byte_nxt;
      sel_r <= sel_nxt;
      daddr_r <= daddr_nxt;
      dwr_r <= dwr_nxt;
      dwdata_r <= dwdata_nxt;
      dact_r <= dma_run_nxt;
      oam_idx_r <= oam_idx_nxt;
      oam_dma_r <= oam_dma_nxt;
      oam_wd_r <= in_write_data;
    end
  end

  // video ram: clearing pass after reset, then bus writes
  always_ff @(posedge clk) begin
    if (busy) begin
      vram[clr_r[mmd_pkg::RAM_AW-1:0]] <= 8'h00;
    end else if (acc && vram_we) begin
      vram[in_address[mmd_pkg::RAM_AW-1:0]] <= in_write_data;
    end
    if (acc) begin
      vram_q_r <= vram[a[mmd_pkg::RAM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wram_we) begin
      wram[in_address[mmd_pkg::RAM_AW-1:0]] <= in_write_data;
    end
    if (acc) begin
      wram_q_r <= wram[a[mmd_pkg::RAM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (acc && hram_we) begin
      hram[in_address[6:0]] <= in_write_data;
    end
    if (acc) begin
      hram_q_r <= hram[a[6:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (acc && boot_we) begin
      boot[in_address[7:0]] <= in_write_data;
    end
    if (acc) begin
      boot_q_r <= boot[a[7:0]];
    end
  end

  // sprite table: written in the cycle after the item, read at the accept edge
  always_ff @(posedge clk) begin
    if (v_r && oam_we_r) begin
      oam[oam_idx_r] <= oam_wdata;
    end
    if (acc) begin
      oam_q_r <= oam[a[7:0]];
    end
  end

  assign out_strobe = v_r;
  assign out_read_data = rd_data;
  assign out_device_select = sel_r;
  assign out_device_address = daddr_r;
  assign out_device_write = dwr_r;
  assign out_device_write_data = dwdata_r;
  assign out_dma_active = dact_r;

  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy))
    else $error("result without an accepted item");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !out_strobe)
    else $error("result during clearing pass");

  a_dma_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    dma_idx_r < 8'(mmd_pkg::DMA_LENGTH))
    else $error("dma index out of range");

  a_dma_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !dma_run_r |-> (dma_idx_r == 8'h00 && dma_src_r == 16'h0000))
    else $error("dma state not cleared");

  a_write_has_device: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_device_write) |-> out_device_select != mmd_pkg::DEV_NONE)
    else $error("forwarded write without a device");

endmodule
`default_nettype wire

@@ dv/memory_map_decoder_with_oam_dma_tb.sv @@
`default_nettype none
module memory_map_decoder_with_oam_dma_tb;

  // one bus result as seen on the out_ ports
  typedef struct packed {
    logic [7:0]  rdata;
    logic [2:0]  sel;
    logic [15:0] daddr;
    logic        dwr;
    logic [7:0]  dwdata;
    logic        dma;
  } bus_res_t;

  // shadow of the decoder: memories, registers and dma progress
  class bus_shadow;
    logic [7:0]  vram [mmd_pkg::RAM_BYTES];
    logic [7:0]  wram [mmd_pkg::RAM_BYTES];
    logic [7:0]  oam [mmd_pkg::SPRITE_BYTES];
    logic [7:0]  hram [mmd_pkg::HIGH_BYTES];
    logic [7:0]  boot [mmd_pkg::BOOT_IMAGE_BYTES];
    logic [7:0]  ie, iflag;
    logic        boot_on, dma_on;
    logic [15:0] dma_src;
    logic [7:0]  dma_idx;
    bus_res_t    pending[$];
    int          errors;

    function void clear(bit boot_reset);
      foreach (vram[i]) vram[i] = 0;
      foreach (wram[i]) wram[i] = 0;
      foreach (oam[i]) oam[i] = 8'hFF;
      foreach (hram[i]) hram[i] = 0;
      foreach (boot[i]) boot[i] = 0;
      ie = 0; iflag = 0; boot_on = boot_reset;
      dma_on = 0; dma_src = 0; dma_idx = 0;
    endfunction

    function mmd_pkg::dev_t route(logic [15:0] a, bit wr);
      if (a < 16'h8000)
        return (!wr && boot_on && a < 16'h0100) ? mmd_pkg::DEV_NONE : mmd_pkg::DEV_CART;
      if (a >= 16'hA000 && a <= 16'hBFFF) return mmd_pkg::DEV_CART;
      if (a >= 16'hFF10 && a <= 16'hFF3F) return mmd_pkg::DEV_APU;
      if (a == 16'hFF00) return mmd_pkg::DEV_JOYPAD;
      if (a == 16'hFF01 || a == 16'hFF02) return mmd_pkg::DEV_SERIAL;
      if (a >= 16'hFF04 && a <= 16'hFF07) return mmd_pkg::DEV_TIMER;
      if (a >= 16'hFF40 && a <= 16'hFF4B && a != mmd_pkg::DMA_REG)
        return (wr && a == mmd_pkg::LY_REG) ? mmd_pkg::DEV_NONE : mmd_pkg::DEV_PPU;
      return mmd_pkg::DEV_NONE;
    endfunction

    function logic [7:0] local_rd(logic [15:0] a, logic [1:0] mode);
      if (a < 16'h0100 && boot_on) return boot[a[7:0]];
      if (a >= 16'h8000 && a < 16'hA000) return vram[a[12:0]];
      if (a >= 16'hC000 && a < 16'hE000) return wram[a[12:0]];
      if (a >= mmd_pkg::OAM_BASE && a < mmd_pkg::OAM_END)
        return mode[1] ? 8'hFF : oam[a - mmd_pkg::OAM_BASE];
      if (a == mmd_pkg::IF_REG) return iflag;
      if (a == mmd_pkg::DMA_REG) return dma_src[15:8];
      if (a == mmd_pkg::BOOT_REG) return {7'd0, boot_on};
      if (a >= mmd_pkg::HRAM_BASE && a < mmd_pkg::IE_REG) return hram[a - mmd_pkg::HRAM_BASE];
      if (a == mmd_pkg::IE_REG) return ie;
      return 8'hFF;
    endfunction

    function void local_wr(logic [15:0] a, logic [7:0] v);
      if (a >= 16'h8000 && a < 16'hA000) vram[a[12:0]] = v;
      else if (a >= 16'hC000 && a < 16'hE000) wram[a[12:0]] = v;
      else if (a >= mmd_pkg::OAM_BASE && a < mmd_pkg::OAM_END) oam[a - mmd_pkg::OAM_BASE] = v;
      else if (a == mmd_pkg::IF_REG) iflag = v;
      else if (a == mmd_pkg::DMA_REG) begin
        dma_on = 1; dma_idx = 0; dma_src = {v, 8'd0};
      end else if (a == mmd_pkg::BOOT_REG) begin
        if (v != 0) boot_on = 0;
      end else if (a >= mmd_pkg::HRAM_BASE && a < mmd_pkg::IE_REG)
        hram[a - mmd_pkg::HRAM_BASE] = v;
      else if (a == mmd_pkg::IE_REG) ie = v;
    endfunction

    // note an accepted item and queue the result it must give
    function void note_item(mmd_pkg::act_t act, logic [15:0] a, logic [7:0] wd,
                            logic [1:0] mode, logic [7:0] dd);
      bus_res_t r;
      logic [15:0] s;
      r = '0;
      case (act)
        mmd_pkg::ACT_READ: begin
          r.sel = route(a, 0);
          if (r.sel != mmd_pkg::DEV_NONE) begin
            r.daddr = a; r.rdata = dd;
          end else r.rdata = local_rd(a, mode);
        end
        mmd_pkg::ACT_WRITE: begin
          r.sel = route(a, 1);
          if (r.sel != mmd_pkg::DEV_NONE) begin
            r.daddr = a; r.dwr = 1; r.dwdata = wd;
          end else local_wr(a, wd);
        end
        mmd_pkg::ACT_TICK: begin
          if (dma_on) begin
            s = dma_src + {8'h00, dma_idx};
            r.sel = route(s, 0);
            if (r.sel != mmd_pkg::DEV_NONE) begin
              r.daddr = s; r.rdata = dd;
            end else r.rdata = local_rd(s, mode);
            oam[dma_idx] = r.rdata;
            dma_idx++;
            if (dma_idx >= mmd_pkg::DMA_LENGTH) begin
              dma_on = 0; dma_idx = 0; dma_src = 0;
            end
          end
        end
        default: if (a < mmd_pkg::BOOT_IMAGE_BYTES) boot[a[7:0]] = wd;
      endcase
      r.dma = dma_on;
      pending.push_back(r);
    endfunction

    function void check_result(bus_res_t got);
      bus_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: rdata %h/%h sel %0d/%0d daddr %h/%h dwr %b/%b dwdata %h/%h dma %b/%b",
                   want.rdata, got.rdata, want.sel, got.sel, want.daddr, got.daddr,
                   want.dwr, got.dwr, want.dwdata, got.dwdata, want.dma, got.dma);
      end
    endfunction
  endclass

  logic        clk, rst_n, start, busy;
  logic [1:0]  in_action, in_ppu_mode;
  logic [15:0] in_address;
  logic [7:0]  in_write_data, in_device_read_data;
  logic        out_strobe, out_device_write, out_dma_active;
  logic [7:0]  out_read_data, out_device_write_data;
  logic [2:0]  out_device_select;
  logic [15:0] out_device_address;
  logic        cfg_we, cfg_wdata;

  bus_shadow shadow;
  int idle_cycles;
  // work ram and high ram bytes written so far; unwritten ones are never read
  bit wram_ok [mmd_pkg::RAM_BYTES];
  bit hram_ok [mmd_pkg::HIGH_BYTES];

  memory_map_decoder_with_oam_dma DUT (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // results cannot be held off, so just check every strobe
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      shadow.check_result({out_read_data, out_device_select, out_device_address,
                           out_device_write, out_device_write_data, out_dma_active});
  end

  // watchdog: counts cycles with nothing accepted; the limit sits well above the
  // length of the clearing pass after reset
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 40000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly back to back, sometimes short gaps, rarely long ones
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 60) n = 0;
    else if (n < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // present one item and hold it until the block takes it
  task automatic send_item(mmd_pkg::act_t act, logic [15:0] a, logic [7:0] wd,
                           logic [1:0] mode, logic [7:0] dd);
    start <= 1; in_action <= act; in_address <= a;
    in_write_data <= wd; in_ppu_mode <= mode; in_device_read_data <= dd;
    do @(posedge clk); while (busy);
    shadow.note_item(act, a, wd, mode, dd);
    if (act == mmd_pkg::ACT_WRITE && a >= 16'hC000 && a < 16'hE000) wram_ok[a[12:0]] = 1;
    if (act == mmd_pkg::ACT_WRITE && a >= mmd_pkg::HRAM_BASE && a < mmd_pkg::IE_REG)
      hram_ok[a - mmd_pkg::HRAM_BASE] = 1;
    idle_gap();
  endtask

  task automatic write_cfg(bit v);
    start <= 0;
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    shadow.boot_on = v;
  endtask

  // random address biased toward interesting regions
  function automatic logic [15:0] pick_addr(bit rd);
    logic [15:0] a;
    case ($urandom_range(0, 11))
      0: a = 16'($urandom_range(0, 16'h01FF));
      1: a = 16'($urandom_range(16'h8000, 16'h9FFF));
      2: a = 16'($urandom_range(16'hC000, 16'hDFFF));
      3, 4: a = 16'($urandom_range(mmd_pkg::OAM_BASE, mmd_pkg::OAM_END + 2));
      5: a = 16'($urandom_range(16'hFF00, 16'hFF7F));
      6: a = 16'($urandom_range(mmd_pkg::HRAM_BASE, mmd_pkg::IE_REG));
      7: a = 16'($urandom_range(16'hFF40, 16'hFF50));
      8: a = mmd_pkg::IE_REG;
      9: a = mmd_pkg::IF_REG;
      default: a = 16'($urandom_range(0, 16'hFFFF));
    endcase
    // keep reads away from never-written work ram and high ram
    if (rd && a >= 16'hC000 && a < 16'hE000 && !wram_ok[a[12:0]]) a = 16'hFEB0;
    if (rd && a >= 16'hE000 && a < 16'hFE00) a = 16'($urandom_range(16'hE000, 16'hFDFF));
    if (rd && a >= mmd_pkg::HRAM_BASE && a < mmd_pkg::IE_REG &&
        !hram_ok[a - mmd_pkg::HRAM_BASE]) a = mmd_pkg::IE_REG;
    return a;
  endfunction

  // dma source page: avoid ones that would read unwritten work ram or high ram
  function automatic logic [7:0] pick_page();
    logic [7:0] p;
    p = 8'($urandom_range(0, 255));
    if (p >= 8'hC0 && p < 8'hE0) p = 8'h80 + {3'd0, p[4:0]};
    if (p == 8'hFF) p = 8'hFE;
    return p;
  endfunction

  initial begin
    int i;
    shadow = new();
    shadow.clear(1);
    idle_cycles = 0;
    rst_n = 0; start = 0; cfg_we = 0; cfg_wdata = 0;
    in_action = mmd_pkg::ACT_READ; in_address = 0; in_write_data = 0;
    in_ppu_mode = 0; in_device_read_data = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // boot image first, so the overlay never reads an unwritten byte
    for (i = 0; i < mmd_pkg::BOOT_IMAGE_BYTES; i++)
      send_item(mmd_pkg::ACT_LOAD, 16'(i), 8'($urandom_range(0, 255)), 2'd0, 8'h00);
    // directed: extremes, forwarded devices, special registers
    send_item(mmd_pkg::ACT_LOAD, 16'hFFFF, 8'hAA, 2'd0, 8'h00);     // load out of range
    send_item(mmd_pkg::ACT_READ, 16'h0000, 8'h00, 2'd0, 8'h55);     // boot overlay
    send_item(mmd_pkg::ACT_READ, 16'h7FFF, 8'h00, 2'd3, 8'hFF);
    send_item(mmd_pkg::ACT_WRITE, 16'h0000, 8'hFF, 2'd0, 8'h00);    // cartridge write
    send_item(mmd_pkg::ACT_WRITE, mmd_pkg::LY_REG, 8'h12, 2'd0, 8'h00); // dropped
    send_item(mmd_pkg::ACT_READ, mmd_pkg::LY_REG, 8'h00, 2'd1, 8'h99);
    send_item(mmd_pkg::ACT_WRITE, mmd_pkg::OAM_BASE, 8'h00, 2'd3, 8'h00); // never blocked
    send_item(mmd_pkg::ACT_READ, mmd_pkg::OAM_BASE, 8'h00, 2'd2, 8'h00);  // blocked read
    send_item(mmd_pkg::ACT_READ, mmd_pkg::OAM_BASE, 8'h00, 2'd0, 8'h00);
    send_item(mmd_pkg::ACT_READ, 16'h9FFF, 8'h00, 2'd0, 8'h00);
    send_item(mmd_pkg::ACT_WRITE, mmd_pkg::IE_REG, 8'hFF, 2'd0, 8'h00);
    send_item(mmd_pkg::ACT_READ, mmd_pkg::IE_REG, 8'h00, 2'd0, 8'h00);
    send_item(mmd_pkg::ACT_WRITE, mmd_pkg::IF_REG, 8'h5A, 2'd0, 8'h00);
    send_item(mmd_pkg::ACT_READ, mmd_pkg::IF_REG, 8'h00, 2'd0, 8'h00);
    send_item(mmd_pkg::ACT_READ, 16'hFF03, 8'h00, 2'd0, 8'h00);     // unmapped
    send_item(mmd_pkg::ACT_TICK, 16'h0000, 8'h00, 2'd0, 8'h00);     // idle tick
    send_item(mmd_pkg::ACT_WRITE, mmd_pkg::BOOT_REG, 8'h00, 2'd0, 8'h00); // zero keeps map
    send_item(mmd_pkg::ACT_READ, mmd_pkg::BOOT_REG, 8'h00, 2'd0, 8'h00);
    send_item(mmd_pkg::ACT_WRITE, mmd_pkg::DMA_REG, 8'h80, 2'd0, 8'h00);
    send_item(mmd_pkg::ACT_READ, mmd_pkg::DMA_REG, 8'h00, 2'd0, 8'h00);
    send_item(mmd_pkg::ACT_TICK, 16'h0000, 8'h00, 2'd0, 8'h00);
    send_item(mmd_pkg::ACT_WRITE, mmd_pkg::DMA_REG, 8'hFE, 2'd0, 8'h00); // restart in oam
    for (i = 0; i < mmd_pkg::DMA_LENGTH; i++)
      send_item(mmd_pkg::ACT_TICK, 16'h0000, 8'h00, 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)));
    send_item(mmd_pkg::ACT_WRITE, mmd_pkg::BOOT_REG, 8'h01, 2'd0, 8'h00); // unmap
    send_item(mmd_pkg::ACT_READ, 16'h0000, 8'h00, 2'd0, 8'h3C);

    // random phases across both register settings
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(ph[0] ? 1'b0 : 1'b1);
      for (i = 0; i < 400; i++) begin
        int k;
        logic [15:0] a;
        k = $urandom_range(0, 99);
        if (k < 30) begin
          a = pick_addr(1);
          send_item(mmd_pkg::ACT_READ, a, 8'($urandom_range(0, 255)),
                    2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end else if (k < 60) begin
          a = pick_addr(0);
          send_item(mmd_pkg::ACT_WRITE, a,
                    (a == mmd_pkg::BOOT_REG && $urandom_range(0, 3) != 0) ? 8'h00 :
                    8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                    8'($urandom_range(0, 255)));
        end else if (k < 62) begin
          send_item(mmd_pkg::ACT_WRITE, mmd_pkg::DMA_REG, pick_page(), 2'd0, 8'h00);
        end else if (k < 95) begin
          send_item(mmd_pkg::ACT_TICK, 16'($urandom_range(0, 16'hFFFF)), 8'h00,
                    2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end else begin
          send_item(mmd_pkg::ACT_LOAD, 16'($urandom_range(0, 300)),
                    8'($urandom_range(0, 255)), 2'd0, 8'h00);
        end
      end
    end

    start <= 0;
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (shadow.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
